@@ hw/rtl/lamp_mode_arbiter_top_assert.svh @@
// Assertion macros for the lamp mode arbiter top level.
// Relies on clock and reset being in scope where a macro is used.
`ifndef LAMP_MODE_ARBITER_TOP_ASSERT_SVH
`define LAMP_MODE_ARBITER_TOP_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define LMA_ASSERT_SAME(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("lamp_mode_arbiter assertion failed");

// Next-cycle implication, masked during reset.
`define LMA_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("lamp_mode_arbiter assertion failed");

`endif

@@ hw/rtl/lma_pkg.sv @@
// Shared widths, codes, constants and types of the lamp mode arbiter.
// No dependencies; every other RTL file but the assertion header imports this package.
package lma_pkg;

   localparam int LAMP_COUNT    = 5;
   localparam int SCENE_COUNT   = 5;
   localparam int NUM_MASK_REGS = 5;

   localparam int LAMP_W      = 5;
   localparam int KIND_W      = 3;
   localparam int SRC_W       = 2;
   localparam int SCENE_W     = 3;
   localparam int RAW_MASK_W  = 8;
   localparam int MODE_W      = 2;
   localparam int SECS_W      = 16;
   localparam int OVR_REM_W   = 26;
   localparam int LEFT_W      = 16;
   localparam int REJ_W       = 16;
   localparam int CSR_INDEX_W = 3;

   localparam logic [LAMP_W-1:0] LAMP_TRIM =
      LAMP_W'(((1 << LAMP_COUNT) - 1) & 'h1F);
   localparam logic [LAMP_W-1:0] ALL_ON = LAMP_TRIM & LAMP_W'('h1F);

   localparam logic [SCENE_W-1:0]     SCENE_MAX     = SCENE_W'(SCENE_COUNT);
   localparam logic [SCENE_W-1:0]     MASK_ID_MAX   = SCENE_W'(NUM_MASK_REGS);
   localparam logic [SCENE_W-1:0]     SCENE_BLANK   = SCENE_W'(0);
   localparam logic [SCENE_W-1:0]     SCENE_ALARM   = SCENE_W'(4);
   localparam logic [OVR_REM_W-1:0]   MS_PER_SECOND = OVR_REM_W'(1000);
   localparam logic [OVR_REM_W-1:0]   LEFT_SAT      = OVR_REM_W'('hFFFF);
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_END = CSR_INDEX_W'(NUM_MASK_REGS);

   typedef enum logic [KIND_W-1:0] {
      KIND_SCENE    = 3'd0,
      KIND_BITS     = 3'd1,
      KIND_SET_MODE = 3'd2,
      KIND_OVERRIDE = 3'd3,
      KIND_TICK     = 3'd4
   } lma_kind_type;

   typedef enum logic [SRC_W-1:0] {
      SRC_LOCAL    = 2'd0,
      SRC_REMOTE   = 2'd1,
      SRC_SCHEDULE = 2'd2
   } lma_source_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_MANUAL    = 2'd0,
      MODE_SMART     = 2'd1,
      MODE_EMERGENCY = 2'd2
   } lma_mode_type;

   typedef logic [LAMP_W-1:0] lma_mask_type;
   typedef lma_mask_type [NUM_MASK_REGS-1:0] lma_masks_type;

   // Scene 1 sits in the lowest slot.
   localparam lma_masks_type SCENE_MASK_RESET = {5'd0, 5'd31, 5'd1, 5'd5, 5'd31};

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [SRC_W-1:0]      source;
      logic [SCENE_W-1:0]    scene_id;
      logic [RAW_MASK_W-1:0] lamp_mask;
      logic [MODE_W-1:0]     new_mode;
      logic [SECS_W-1:0]     override_seconds;
   } lma_req_type;

   typedef struct packed {
      logic        valid;
      lma_req_type req;
   } lma_stage_type;

   typedef struct packed {
      logic               accepted;
      logic [LAMP_W-1:0]  lamp_bits;
      logic [MODE_W-1:0]  current_mode;
      logic [SCENE_W-1:0] active_scene;
      logic               override_on;
      logic [LEFT_W-1:0]  override_left_ms;
      logic [REJ_W-1:0]   reject_total;
   } lma_rsp_type;

endpackage

@@ hw/rtl/lma_if.sv @@
// Request, response and register-write channel interfaces.
// Depends on lma_pkg for field widths.
interface lma_req_if;
   import lma_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [KIND_W-1:0]     kind;
   logic [SRC_W-1:0]      origin;
   logic [SCENE_W-1:0]    scene_id;
   logic [RAW_MASK_W-1:0] lamp_mask;
   logic [MODE_W-1:0]     new_mode;
   logic [SECS_W-1:0]     override_seconds;

   modport source (output valid, kind, origin, scene_id, lamp_mask, new_mode,
                   override_seconds, input ready);
   modport sink (input valid, kind, origin, scene_id, lamp_mask, new_mode,
                 override_seconds, output ready);
endinterface

interface lma_rsp_if;
   import lma_pkg::*;
   logic               valid;
   logic               ready;
   logic               accepted;
   logic [LAMP_W-1:0]  lamp_bits;
   logic [MODE_W-1:0]  current_mode;
   logic [SCENE_W-1:0] active_scene;
   logic               override_on;
   logic [LEFT_W-1:0]  override_left_ms;
   logic [REJ_W-1:0]   reject_total;

   modport source (output valid, accepted, lamp_bits, current_mode, active_scene,
                   override_on, override_left_ms, reject_total, input ready);
   modport sink (input valid, accepted, lamp_bits, current_mode, active_scene,
                 override_on, override_left_ms, reject_total, output ready);
endinterface

interface lma_csr_if;
   import lma_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [LAMP_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/lamp_mode_arbiter_top.sv @@
// A request transaction, once taken, passes the input register and then the
// result register fed by the arbitration logic.
// Throughput: one transaction per cycle, held back only by a stalled result.
// Reset clears mode, scene, lamps, override window and reject counter and
// restores the scene masks; no clearing pass, the block is ready right away.
// Depends on lma_pkg, lma_if, lma_csr_regs, lma_in_reg, lma_engine.
module lamp_mode_arbiter_top (
   input  logic      clock,
   input  logic      reset,
   lma_req_if.sink   req_chan,
   lma_rsp_if.source rsp_chan,
   lma_csr_if.sink   csr_chan
);
   import lma_pkg::*;

`include "lamp_mode_arbiter_top_assert.svh"

   lma_masks_type masks;
   lma_stage_type stage;
   logic          take;

   lma_csr_regs u_csr_regs (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .masks    (masks)
   );

   lma_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .stage    (stage)
   );

   lma_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .stage    (stage),
      .masks    (masks),
      .take     (take),
      .rsp_chan (rsp_chan)
   );

   `LMA_ASSERT_NEXT(a_take_fills_rsp, take, rsp_chan.valid)
   `LMA_ASSERT_SAME(a_no_take_on_stall, rsp_chan.valid && !rsp_chan.ready, !take)
   `LMA_ASSERT_NEXT(a_tick_not_accepted, take && (stage.req.kind == KIND_TICK), !rsp_chan.accepted)
   `LMA_ASSERT_SAME(a_closed_window_zero, rsp_chan.valid && !rsp_chan.override_on,
                    rsp_chan.override_left_ms == '0)

endmodule

@@ hw/rtl/lma_csr_regs.sv @@
// Scene mask registers written through the register-write channel.
// Depends on lma_pkg and lma_csr_if.
module lma_csr_regs (
   input  logic                   clock,
   input  logic                   reset,
   lma_csr_if.sink                csr_chan,
   output lma_pkg::lma_masks_type masks
);
   import lma_pkg::*;

   lma_masks_type masks_ff;
   lma_masks_type masks_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      masks_in = masks_ff;
      // Drop writes beyond the mask registers.
      if (csr_chan.valid && (csr_chan.index < CSR_INDEX_END)) begin
         masks_in[csr_chan.index] = csr_chan.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         masks_ff <= SCENE_MASK_RESET;
      end else begin
         masks_ff <= masks_in;
      end
   end

   assign masks = masks_ff;

endmodule

@@ hw/rtl/lma_in_reg.sv @@
// Input register: captures one request transaction and holds it for the engine.
// Depends on lma_pkg and lma_req_if.
module lma_in_reg (
   input  logic                   clock,
   input  logic                   reset,
   lma_req_if.sink                req_chan,
   input  logic                   take,
   output lma_pkg::lma_stage_type stage
);
   import lma_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   lma_req_type req_ff;
   logic        load;

   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         req_ff.kind             <= req_chan.kind;
         req_ff.source           <= req_chan.origin;
         req_ff.scene_id         <= req_chan.scene_id;
         req_ff.lamp_mask        <= req_chan.lamp_mask;
         req_ff.new_mode         <= req_chan.new_mode;
         req_ff.override_seconds <= req_chan.override_seconds;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.req   = req_ff;

endmodule

@@ hw/rtl/lma_engine.sv @@
// Arbitration engine: mode, scene, lamp, override and reject state plus
// the result register. Depends on lma_pkg and lma_rsp_if.
module lma_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  lma_pkg::lma_stage_type stage,
   input  lma_pkg::lma_masks_type masks,
   output logic                   take,
   lma_rsp_if.source              rsp_chan
);
   import lma_pkg::*;

   lma_mode_type         mode_ff, mode_in;
   logic [SCENE_W-1:0]   scene_ff, scene_in;
   logic [LAMP_W-1:0]    bits_ff, bits_in;
   logic                 ovr_flag_ff, ovr_flag_in;
   logic [OVR_REM_W-1:0] ovr_rem_ff, ovr_rem_in;
   logic [REJ_W-1:0]     rej_ff, rej_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   lma_rsp_type          rsp_data_ff, rsp_data_in;

   logic                 src_ok;
   logic                 acc;
   logic [LAMP_W-1:0]    scene_mask;
   logic [OVR_REM_W-1:0] rem_dec;
   logic [SCENE_W-1:0]   mask_index;

   assign take = stage.valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      unique case (mode_ff)
         MODE_EMERGENCY: src_ok = (stage.req.source == SRC_LOCAL);
         MODE_MANUAL:    src_ok = (stage.req.source != SRC_SCHEDULE);
         MODE_SMART:     src_ok = (stage.req.source == SRC_LOCAL) ||
                                  (stage.req.source == SRC_SCHEDULE) ||
                                  ((stage.req.source == SRC_REMOTE) && ovr_flag_ff);
         default:        src_ok = 1'b0;
      endcase
   end

   // Scene IDs past the mask registers light nothing.
   assign mask_index = stage.req.scene_id - SCENE_W'(1);
   always_comb begin
      scene_mask = '0;
      if ((stage.req.scene_id != SCENE_BLANK) && (stage.req.scene_id <= MASK_ID_MAX)) begin
         scene_mask = masks[mask_index] & LAMP_TRIM;
      end
   end

   assign rem_dec = (ovr_rem_ff != '0) ? (ovr_rem_ff - OVR_REM_W'(1)) : ovr_rem_ff;

   always_comb begin
      mode_in     = mode_ff;
      scene_in    = scene_ff;
      bits_in     = bits_ff;
      ovr_flag_in = ovr_flag_ff;
      ovr_rem_in  = ovr_rem_ff;
      rej_in      = rej_ff;
      acc         = 1'b0;

      unique case (stage.req.kind)
         KIND_SCENE: begin
            if (!src_ok || (stage.req.scene_id == SCENE_BLANK) ||
                (stage.req.scene_id > SCENE_MAX)) begin
               rej_in = rej_ff + REJ_W'(1);
            end else begin
               scene_in = stage.req.scene_id;
               bits_in  = scene_mask;
               acc      = 1'b1;
            end
         end
         KIND_BITS: begin
            if (!src_ok) begin
               rej_in = rej_ff + REJ_W'(1);
            end else begin
               scene_in = SCENE_BLANK;
               bits_in  = stage.req.lamp_mask[LAMP_W-1:0] & LAMP_TRIM;
               acc      = 1'b1;
            end
         end
         KIND_SET_MODE: begin
            if ((stage.req.new_mode == MODE_MANUAL) || (stage.req.new_mode == MODE_SMART) ||
                (stage.req.new_mode == MODE_EMERGENCY)) begin
               acc = 1'b1;
               if (stage.req.new_mode != mode_ff) begin
                  mode_in = lma_mode_type'(stage.req.new_mode);
                  if (stage.req.new_mode == MODE_EMERGENCY) begin
                     scene_in = SCENE_ALARM;
                     bits_in  = ALL_ON;
                  end else begin
                     ovr_flag_in = 1'b0;
                     ovr_rem_in  = '0;
                  end
               end
            end
         end
         KIND_OVERRIDE: begin
            if (mode_ff == MODE_SMART) begin
               acc = 1'b1;
               if (stage.req.override_seconds == '0) begin
                  ovr_flag_in = 1'b0;
                  ovr_rem_in  = '0;
               end else begin
                  ovr_flag_in = 1'b1;
                  ovr_rem_in  = OVR_REM_W'(stage.req.override_seconds) * MS_PER_SECOND;
               end
            end
         end
         KIND_TICK: begin
            // Count the window down and close it on reaching zero.
            if (ovr_flag_ff) begin
               ovr_rem_in = rem_dec;
               if (rem_dec == '0) begin
                  ovr_flag_in = 1'b0;
               end
            end
            if (mode_ff == MODE_EMERGENCY) begin
               bits_in = ALL_ON;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_data_in.accepted         = acc;
      rsp_data_in.lamp_bits        = bits_in;
      rsp_data_in.current_mode     = mode_in;
      rsp_data_in.active_scene     = scene_in;
      rsp_data_in.override_on      = ovr_flag_in;
      rsp_data_in.override_left_ms = '0;
      if (ovr_flag_in) begin
         rsp_data_in.override_left_ms = (ovr_rem_in > LEFT_SAT) ? LEFT_SAT[LEFT_W-1:0]
                                                                : ovr_rem_in[LEFT_W-1:0];
      end
      rsp_data_in.reject_total     = rej_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_MANUAL;
         scene_ff     <= SCENE_BLANK;
         bits_ff      <= '0;
         ovr_flag_ff  <= 1'b0;
         ovr_rem_ff   <= '0;
         rej_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            mode_ff     <= mode_in;
            scene_ff    <= scene_in;
            bits_ff     <= bits_in;
            ovr_flag_ff <= ovr_flag_in;
            ovr_rem_ff  <= ovr_rem_in;
            rej_ff      <= rej_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.accepted         = rsp_data_ff.accepted;
   assign rsp_chan.lamp_bits        = rsp_data_ff.lamp_bits;
   assign rsp_chan.current_mode     = rsp_data_ff.current_mode;
   assign rsp_chan.active_scene     = rsp_data_ff.active_scene;
   assign rsp_chan.override_on      = rsp_data_ff.override_on;
   assign rsp_chan.override_left_ms = rsp_data_ff.override_left_ms;
   assign rsp_chan.reject_total     = rsp_data_ff.reject_total;

endmodule
